// ----- hdl/voxel_terrain_column_span_macros.svh -----
// assertion macros for the voxel terrain column span checker
`ifndef VOXEL_TERRAIN_COLUMN_SPAN_MACROS_SVH
`define VOXEL_TERRAIN_COLUMN_SPAN_MACROS_SVH

// implication in the same cycle, clocked on i_clk, off while i_rst_n is low
`define VTCS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication in the next cycle
`define VTCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/vtcs_pkg.sv -----
// shared types and constants of the voxel terrain column span block
package vtcs_pkg;

    localparam int COL_W    = 11;
    localparam int DEPTH_W  = 17;
    localparam int TEXEL_W  = 32;
    localparam int ROW_W    = 10;
    localparam int CAM_W    = 12;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 2;
    localparam int HGT_W    = 8;
    localparam int HEIGHT_LSB = 24;
    localparam int COLOR_W  = 24;
    localparam int NUM_W    = 30;
    localparam int STEPS    = 30;
    localparam int CNT_W    = 5;
    localparam int V_W      = 32;

    localparam logic [HGT_W-1:0] ALPHA_OPAQUE = 8'hFF;

    localparam logic CMD_CLEAR  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HORIZON_ROW   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS   = 2'd3;

    localparam logic signed [CAM_W-1:0] CAMERA_HEIGHT_RST = 12'sd200;
    localparam logic [ROW_W-1:0] HEIGHT_SCALE_RST = 10'd240;
    localparam logic [ROW_W-1:0] HORIZON_ROW_RST  = 10'd120;
    localparam logic [ROW_W-1:0] SCREEN_ROWS_RST  = 10'd720;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_DIV,
        S_PROJ,
        S_FIN
    } t_state;

    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] top;
    } t_col_entry;

endpackage

// ----- hdl/vtcs_col_store.sv -----
// per-column occlusion store: single-port synchronous memory of valid and top
module vtcs_col_store #(
    parameter int COLUMNS = 1280,
    parameter int AW      = 11
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_addr,
    input  vtcs_pkg::t_col_entry  i_wdata,
    output vtcs_pkg::t_col_entry  o_rdata
);

    vtcs_pkg::t_col_entry r_mem [COLUMNS];
    vtcs_pkg::t_col_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/vtcs_div.sv -----
// restoring unsigned divider, one quotient bit per cycle
module vtcs_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [vtcs_pkg::NUM_W-1:0]    i_num,
    input  logic [vtcs_pkg::DEPTH_W-1:0]  i_den,
    output logic                          o_done,
    output logic [vtcs_pkg::NUM_W-1:0]    o_quo,
    output logic                          o_rem_nz
);

    logic                          r_busy;
    logic                          r_done;
    logic [vtcs_pkg::CNT_W-1:0]    r_cnt;
    logic [vtcs_pkg::NUM_W-1:0]    r_num;
    logic [vtcs_pkg::DEPTH_W-1:0]  r_rem;
    logic [vtcs_pkg::DEPTH_W-1:0]  r_den;

    logic [vtcs_pkg::DEPTH_W:0]    w_sh;
    logic [vtcs_pkg::DEPTH_W:0]    w_diff;
    logic                          w_ge;

    always_comb begin
        w_sh   = {r_rem, r_num[vtcs_pkg::NUM_W-1]};
        w_ge   = (w_sh >= {1'b0, r_den});
        w_diff = w_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == vtcs_pkg::CNT_W'(vtcs_pkg::STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // the numerator register fills with quotient bits from the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[vtcs_pkg::NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[vtcs_pkg::DEPTH_W-1:0] : w_sh[vtcs_pkg::DEPTH_W-1:0];
        end
    end

    assign o_done   = r_done;
    assign o_quo    = r_num;
    assign o_rem_nz = |r_rem;

endmodule

// ----- hdl/voxel_terrain_column_span.sv -----
// voxel terrain column span: projects terrain samples to column spans with occlusion
//
// Each request is either a terrain sample or a frame clear. A sample goes
// through these steps from acceptance to its result being loaded into the
// output register: the height-difference multiply feeds the divider in the
// accept cycle, the restoring divider forms
// |camera_height - height|*scale*256/depth one bit at a time, the divider
// raises its done flag, the horizon offset and clamp are registered, and the
// occlusion compare and the write-back to the column store follow; that last
// step is held while a previous result still waits stalled in the output
// register. A frame clear sweeps the column store, one entry per cycle, before
// its all-zero result is loaded. After reset the same sweep runs with input
// stalled; configuration writes are taken at any time. One request is in work
// at a time; the output register lets the next request be accepted while a
// result waits downstream.
module voxel_terrain_column_span #(
    parameter int COLUMNS = 1280
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_cfg_we,
    input  logic [vtcs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [vtcs_pkg::CFG_W-1:0]     i_cfg_data,

    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_cmd,
    input  logic [vtcs_pkg::COL_W-1:0]     i_column,
    input  logic [vtcs_pkg::DEPTH_W-1:0]   i_depth,
    input  logic [vtcs_pkg::TEXEL_W-1:0]   i_texel,

    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [vtcs_pkg::COL_W-1:0]     o_span_column,
    output logic [vtcs_pkg::ROW_W-1:0]     o_span_top,
    output logic [vtcs_pkg::ROW_W-1:0]     o_span_bottom,
    output logic [vtcs_pkg::TEXEL_W-1:0]   o_pixel,
    output logic                           o_visible
);

    localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    // configuration
    logic signed [vtcs_pkg::CAM_W-1:0] r_cam;
    logic [vtcs_pkg::ROW_W-1:0]        r_scale;
    logic [vtcs_pkg::ROW_W-1:0]        r_horizon;
    logic [vtcs_pkg::ROW_W-1:0]        r_rows;

    // control
    vtcs_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_sweep_cnt;
    logic             r_clr;

    // request payload
    logic [vtcs_pkg::COL_W-1:0]   r_col;
    logic [vtcs_pkg::COLOR_W-1:0] r_color;
    logic                         r_in_range;
    logic                         r_neg;
    logic [vtcs_pkg::ROW_W-1:0]   r_top;

    // output register
    logic                           r_out_valid;
    logic [vtcs_pkg::COL_W-1:0]     r_out_col;
    logic [vtcs_pkg::ROW_W-1:0]     r_out_top;
    logic [vtcs_pkg::ROW_W-1:0]     r_out_bot;
    logic [vtcs_pkg::TEXEL_W-1:0]   r_out_pix;
    logic                           r_out_vis;

    // datapath
    logic                                in_acc;
    logic                                w_in_stall;
    logic                                w_out_free;
    logic                                w_sweep_end;
    logic signed [vtcs_pkg::CAM_W:0]     w_diff;
    logic [vtcs_pkg::CAM_W-1:0]          w_diff_mag;
    logic [vtcs_pkg::NUM_W-1:0]          w_num;
    logic [vtcs_pkg::DEPTH_W-1:0]        w_den;
    logic                                w_col_in_range;
    logic [vtcs_pkg::NUM_W-1:0]          w_quo;
    logic                                w_rem_nz;
    logic                                w_div_done;
    logic signed [vtcs_pkg::V_W-1:0]     w_qs;
    logic signed [vtcs_pkg::V_W-1:0]     w_v;
    logic [vtcs_pkg::ROW_W-1:0]          w_top;
    logic [vtcs_pkg::ROW_W-1:0]          w_bot;
    logic                                w_vis;

    // control outputs
    logic                  w_div_start;
    logic                  w_mem_en;
    logic                  w_mem_we;
    logic [AW-1:0]         w_mem_addr;
    vtcs_pkg::t_col_entry  w_mem_wdata;
    vtcs_pkg::t_col_entry  w_mem_rdata;
    logic                  w_out_load;
    logic                  w_take;

    assign in_acc      = i_in_valid && !w_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_sweep_end = (r_sweep_cnt == AW'(COLUMNS - 1));

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam     <= vtcs_pkg::CAMERA_HEIGHT_RST;
            r_scale   <= vtcs_pkg::HEIGHT_SCALE_RST;
            r_horizon <= vtcs_pkg::HORIZON_ROW_RST;
            r_rows    <= vtcs_pkg::SCREEN_ROWS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vtcs_pkg::CFG_CAMERA_HEIGHT: r_cam     <= i_cfg_data;
                vtcs_pkg::CFG_HEIGHT_SCALE:  r_scale   <= i_cfg_data[vtcs_pkg::ROW_W-1:0];
                vtcs_pkg::CFG_HORIZON_ROW:   r_horizon <= i_cfg_data[vtcs_pkg::ROW_W-1:0];
                vtcs_pkg::CFG_SCREEN_ROWS:   r_rows    <= i_cfg_data[vtcs_pkg::ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // |camera - height| * scale * 256, sign kept apart for floor rounding
    always_comb begin
        w_diff = {r_cam[vtcs_pkg::CAM_W-1], r_cam}
               - $signed({5'd0, i_texel[vtcs_pkg::TEXEL_W-1:vtcs_pkg::HEIGHT_LSB]});
        w_diff_mag = w_diff[vtcs_pkg::CAM_W] ? vtcs_pkg::CAM_W'(-w_diff)
                                             : w_diff[vtcs_pkg::CAM_W-1:0];
        w_num = {vtcs_pkg::NUM_W'(w_diff_mag * r_scale)} << 8;
        w_den = (i_depth == '0) ? vtcs_pkg::DEPTH_W'(1) : i_depth;
        w_col_in_range = (32'(i_column) < COLUMNS);
    end

    vtcs_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_num    (w_num),
        .i_den    (w_den),
        .o_done   (w_div_done),
        .o_quo    (w_quo),
        .o_rem_nz (w_rem_nz)
    );

    // floor quotient, horizon offset and clamp
    always_comb begin
        if (r_neg) begin
            w_qs = -($signed({2'b0, w_quo}) + $signed({31'd0, w_rem_nz}));
        end else begin
            w_qs = $signed({2'b0, w_quo});
        end
        w_v = w_qs + $signed({22'd0, r_horizon});
        if (w_v < 0) begin
            w_top = '0;
        end else if (w_v > $signed({22'd0, r_rows})) begin
            w_top = r_rows;
        end else begin
            w_top = w_v[vtcs_pkg::ROW_W-1:0];
        end
    end

    vtcs_col_store #(
        .COLUMNS (COLUMNS),
        .AW      (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (w_mem_en),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

    // occlusion compare against the stored top
    always_comb begin
        w_bot = (r_in_range && w_mem_rdata.valid) ? w_mem_rdata.top : r_rows;
        w_vis = r_in_range && (r_top < w_bot);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            vtcs_pkg::S_SWEEP: begin
                if (w_sweep_end) begin
                    n_state = r_clr ? vtcs_pkg::S_FIN : vtcs_pkg::S_IDLE;
                end
            end
            vtcs_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_cmd == vtcs_pkg::CMD_CLEAR) ? vtcs_pkg::S_SWEEP
                                                             : vtcs_pkg::S_DIV;
                end
            end
            vtcs_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_state = vtcs_pkg::S_PROJ;
                end
            end
            vtcs_pkg::S_PROJ: begin
                n_state = vtcs_pkg::S_FIN;
            end
            vtcs_pkg::S_FIN: begin
                if (w_out_free) begin
                    n_state = vtcs_pkg::S_IDLE;
                end
            end
            default: n_state = vtcs_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_in_stall  = 1'b1;
        w_div_start = 1'b0;
        w_mem_en    = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_addr  = AW'(r_col);
        w_mem_wdata = '{valid: 1'b1, top: r_top};
        w_out_load  = 1'b0;
        w_take      = 1'b0;
        case (r_state)
            vtcs_pkg::S_SWEEP: begin
                w_mem_en    = 1'b1;
                w_mem_we    = 1'b1;
                w_mem_addr  = r_sweep_cnt;
                w_mem_wdata = '{valid: 1'b0, top: '0};
            end
            vtcs_pkg::S_IDLE: begin
                w_in_stall = 1'b0;
                w_take     = in_acc;
                if (in_acc && i_cmd == vtcs_pkg::CMD_SAMPLE) begin
                    w_div_start = 1'b1;
                    w_mem_en    = 1'b1;
                    w_mem_addr  = AW'(i_column);
                end
            end
            vtcs_pkg::S_FIN: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    if (!r_clr && w_vis) begin
                        w_mem_en = 1'b1;
                        w_mem_we = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_in_stall = w_in_stall;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vtcs_pkg::S_SWEEP;
            r_sweep_cnt <= '0;
            r_clr       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == vtcs_pkg::S_SWEEP) begin
                r_sweep_cnt <= w_sweep_end ? '0 : r_sweep_cnt + 1'b1;
            end
            if (w_take) begin
                r_clr <= (i_cmd == vtcs_pkg::CMD_CLEAR);
            end else if (w_out_load) begin
                r_clr <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_col      <= i_column;
            r_color    <= i_texel[vtcs_pkg::COLOR_W-1:0];
            r_in_range <= w_col_in_range;
            r_neg      <= w_diff[vtcs_pkg::CAM_W];
        end
        if (r_state == vtcs_pkg::S_PROJ) begin
            r_top <= w_top;
        end
        if (w_out_load) begin
            if (r_clr) begin
                r_out_col <= '0;
                r_out_top <= '0;
                r_out_bot <= '0;
                r_out_pix <= '0;
                r_out_vis <= 1'b0;
            end else begin
                r_out_col <= r_col;
                r_out_top <= r_top;
                r_out_bot <= w_bot;
                r_out_pix <= {vtcs_pkg::ALPHA_OPAQUE, r_color};
                r_out_vis <= w_vis;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_span_column = r_out_col;
    assign o_span_top    = r_out_top;
    assign o_span_bottom = r_out_bot;
    assign o_pixel       = r_out_pix;
    assign o_visible     = r_out_vis;

endmodule

// ----- hdl/vtcs_checker.sv -----
// port-level checker for the voxel terrain column span block and its bind
`include "voxel_terrain_column_span_macros.svh"

module vtcs_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_stall,
    input  logic                           o_out_valid,
    input  logic                           i_out_stall,
    input  logic [vtcs_pkg::COL_W-1:0]     o_span_column,
    input  logic [vtcs_pkg::ROW_W-1:0]     o_span_top,
    input  logic [vtcs_pkg::ROW_W-1:0]     o_span_bottom,
    input  logic [vtcs_pkg::TEXEL_W-1:0]   o_pixel,
    input  logic                           o_visible
);

    logic w_out_held;
    logic w_in_take;
    logic w_vis_out;
    logic w_nonempty;
    logic w_opaque;
    logic w_zero_result;

    assign w_out_held    = o_out_valid && i_out_stall;
    assign w_in_take     = i_in_valid && !o_in_stall;
    assign w_vis_out     = o_out_valid && o_visible;
    assign w_nonempty    = o_span_top < o_span_bottom;
    assign w_opaque      = o_pixel[vtcs_pkg::TEXEL_W-1 -: vtcs_pkg::HGT_W] == vtcs_pkg::ALPHA_OPAQUE;
    assign w_zero_result = (o_pixel == '0) && !o_visible && (o_span_column == '0)
                        && (o_span_top == '0) && (o_span_bottom == '0);

    // a stalled result is not dropped
    `VTCS_ASSERT_NEXT(a_out_hold, w_out_held, o_out_valid, "result dropped under stall")

    // a visible span is never empty
    `VTCS_ASSERT_SAME(a_vis_nonempty, w_vis_out, w_nonempty, "visible span is empty")

    // samples carry an opaque pixel, clears carry an all-zero result
    `VTCS_ASSERT_SAME(a_pixel_form, o_out_valid, w_opaque || w_zero_result, "bad pixel or clear result")

    // one request in work at a time
    `VTCS_ASSERT_NEXT(a_one_at_a_time, w_in_take, o_in_stall, "request taken while busy")

endmodule

bind voxel_terrain_column_span vtcs_checker u_vtcs_checker (.*);

// ----- tb/sv/voxel_terrain_column_span_tb.sv -----
// testbench of the voxel terrain column span block: random and directed requests, self-checking
module voxel_terrain_column_span_tb;

    localparam int COLUMNS = 1280;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 225;
    localparam int DRAIN_CYCLES = COLUMNS + 64;
    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic                         cmd;
        logic [vtcs_pkg::COL_W-1:0]   column;
        logic [vtcs_pkg::DEPTH_W-1:0] depth;
        logic [vtcs_pkg::TEXEL_W-1:0] texel;
    } t_request;

    typedef struct packed {
        logic [vtcs_pkg::COL_W-1:0]   column;
        logic [vtcs_pkg::ROW_W-1:0]   top;
        logic [vtcs_pkg::ROW_W-1:0]   bottom;
        logic [vtcs_pkg::TEXEL_W-1:0] pixel;
        logic                         visible;
    } t_span;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [vtcs_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [vtcs_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    logic                           i_cmd = vtcs_pkg::CMD_CLEAR;
    logic [vtcs_pkg::COL_W-1:0]     i_column = '0;
    logic [vtcs_pkg::DEPTH_W-1:0]   i_depth = '0;
    logic [vtcs_pkg::TEXEL_W-1:0]   i_texel = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic [vtcs_pkg::COL_W-1:0]     o_span_column;
    logic [vtcs_pkg::ROW_W-1:0]     o_span_top;
    logic [vtcs_pkg::ROW_W-1:0]     o_span_bottom;
    logic [vtcs_pkg::TEXEL_W-1:0]   o_pixel;
    logic                           o_visible;

    voxel_terrain_column_span #(
        .COLUMNS(COLUMNS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_column      (i_column),
        .i_depth       (i_depth),
        .i_texel       (i_texel),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_span_column (o_span_column),
        .o_span_top    (o_span_top),
        .o_span_bottom (o_span_bottom),
        .o_pixel       (o_pixel),
        .o_visible     (o_visible)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow of the block's registers and column store
    logic signed [vtcs_pkg::CAM_W-1:0] cam_h;
    logic [vtcs_pkg::ROW_W-1:0]        scale;
    logic [vtcs_pkg::ROW_W-1:0]        horizon;
    logic [vtcs_pkg::ROW_W-1:0]        rows;
    logic [vtcs_pkg::ROW_W-1:0]        col_top [COLUMNS];
    bit                                col_set [COLUMNS];

    t_request request_q[$];
    t_span    span_q[$];
    t_request cur_req;
    t_span    got_span;

    bit calm = 1'b0;
    int mismatches = 0;
    int n_samples = 0;
    int n_clears = 0;
    int n_visible = 0;
    int n_offscreen = 0;
    int n_settings = 1;

    function automatic t_span project_span(t_request r);
        t_span  s;
        longint den;
        longint diff;
        longint num;
        longint q;
        longint v;
        bit     on_screen;
        s = '0;
        if (r.cmd == vtcs_pkg::CMD_CLEAR) begin
            col_set = '{default: 1'b0};
            return s;
        end
        den = (r.depth == 0) ? 64'sd1 : longint'(r.depth);
        diff = longint'(cam_h)
             - longint'(r.texel[vtcs_pkg::HEIGHT_LSB +: vtcs_pkg::HGT_W]);
        num = diff * longint'(scale) * 256;
        // round toward minus infinity
        q = (num >= 0) ? num / den : -((-num + den - 1) / den);
        v = q + longint'(horizon);
        if (v < 0)
            v = 0;
        if (v > longint'(rows))
            v = longint'(rows);
        s.column = r.column;
        s.top = v[vtcs_pkg::ROW_W-1:0];
        on_screen = r.column < COLUMNS;
        s.bottom = (on_screen && col_set[r.column]) ? col_top[r.column] : rows;
        s.pixel = {vtcs_pkg::ALPHA_OPAQUE, r.texel[vtcs_pkg::COLOR_W-1:0]};
        if (on_screen && s.top < s.bottom) begin
            s.visible = 1'b1;
            col_top[r.column] = s.top;
            col_set[r.column] = 1'b1;
        end
        return s;
    endfunction

    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < 15);
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatches < MAX_REPORTS)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                got_span = project_span(cur_req);
                span_q.push_back(got_span);
                if (cur_req.cmd == vtcs_pkg::CMD_CLEAR) begin
                    n_clears++;
                end else begin
                    n_samples++;
                    if (got_span.visible)
                        n_visible++;
                    if (cur_req.column >= COLUMNS)
                        n_offscreen++;
                end
            end
            if (!i_in_valid || !o_in_stall) begin
                if (request_q.size() != 0 && !take_break()) begin
                    cur_req = request_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_cmd <= cur_req.cmd;
                    i_column <= cur_req.column;
                    i_depth <= cur_req.depth;
                    i_texel <= cur_req.texel;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // span monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (span_q.size() == 0) begin
                    report_mismatch($sformatf("span for column %0d with no request outstanding",
                                              o_span_column));
                end else begin
                    t_span want;
                    want = span_q.pop_front();
                    if (o_span_column !== want.column)
                        report_mismatch($sformatf("span_column got %0d want %0d",
                                                  o_span_column, want.column));
                    if (o_span_top !== want.top)
                        report_mismatch($sformatf("span_top got %0d want %0d (column %0d)",
                                                  o_span_top, want.top, want.column));
                    if (o_span_bottom !== want.bottom)
                        report_mismatch($sformatf("span_bottom got %0d want %0d (column %0d)",
                                                  o_span_bottom, want.bottom, want.column));
                    if (o_pixel !== want.pixel)
                        report_mismatch($sformatf("pixel got %h want %h", o_pixel, want.pixel));
                    if (o_visible !== want.visible)
                        report_mismatch($sformatf("visible got %b want %b (column %0d)",
                                                  o_visible, want.visible, want.column));
                end
            end
            i_out_stall <= take_break();
        end
    end

    task automatic write_reg(logic [vtcs_pkg::CFG_IDX_W-1:0] idx,
                             logic [vtcs_pkg::CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            vtcs_pkg::CFG_CAMERA_HEIGHT: cam_h = data[vtcs_pkg::CAM_W-1:0];
            vtcs_pkg::CFG_HEIGHT_SCALE:  scale = data[vtcs_pkg::ROW_W-1:0];
            vtcs_pkg::CFG_HORIZON_ROW:   horizon = data[vtcs_pkg::ROW_W-1:0];
            vtcs_pkg::CFG_SCREEN_ROWS:   rows = data[vtcs_pkg::ROW_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(logic [vtcs_pkg::CFG_W-1:0] c, logic [vtcs_pkg::CFG_W-1:0] s,
                                 logic [vtcs_pkg::CFG_W-1:0] h, logic [vtcs_pkg::CFG_W-1:0] r);
        write_reg(vtcs_pkg::CFG_CAMERA_HEIGHT, c);
        write_reg(vtcs_pkg::CFG_HEIGHT_SCALE, s);
        write_reg(vtcs_pkg::CFG_HORIZON_ROW, h);
        write_reg(vtcs_pkg::CFG_SCREEN_ROWS, r);
        n_settings++;
    endtask

    task automatic add_sample(int col, int dep, logic [vtcs_pkg::TEXEL_W-1:0] tex);
        t_request r;
        r.cmd = vtcs_pkg::CMD_SAMPLE;
        r.column = col[vtcs_pkg::COL_W-1:0];
        r.depth = dep[vtcs_pkg::DEPTH_W-1:0];
        r.texel = tex;
        request_q.push_back(r);
    endtask

    task automatic add_clear();
        t_request r;
        r.cmd = vtcs_pkg::CMD_CLEAR;
        // payload ignored on a clear, keep it noisy
        r.column = vtcs_pkg::COL_W'($urandom_range(0, 2047));
        r.depth = vtcs_pkg::DEPTH_W'($urandom_range(0, 131071));
        r.texel = $urandom();
        request_q.push_back(r);
    endtask

    task automatic add_random();
        int pick;
        int col;
        int dep;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            add_clear();
        end else if (pick < 83) begin
            // a few columns revisited often, so occlusion builds up
            col = ($urandom_range(0, 4) == 0) ? $urandom_range(COLUMNS - 16, COLUMNS - 1)
                                              : $urandom_range(0, 15);
            dep = ($urandom_range(0, 9) < 7) ? $urandom_range(256, 8191)
                                             : $urandom_range(256, 131071);
            add_sample(col, dep, $urandom());
        end else begin
            add_sample($urandom_range(0, 2047), $urandom_range(0, 131071), $urandom());
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (request_q.size() != 0 || i_in_valid || span_q.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        cam_h = vtcs_pkg::CAMERA_HEIGHT_RST;
        scale = vtcs_pkg::HEIGHT_SCALE_RST;
        horizon = vtcs_pkg::HORIZON_ROW_RST;
        rows = vtcs_pkg::SCREEN_ROWS_RST;
        col_set = '{default: 1'b0};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, at reset settings
        @(negedge i_clk);
        add_clear();
        add_sample(0, 256, 32'h0000_0000);
        add_sample(0, 256, 32'hFF00_0000);
        add_sample(0, 256, 32'hFF12_3456);
        add_sample(1, 131071, 32'hC8AB_CDEF);
        add_sample(1, 131071, 32'hFFFF_FFFF);
        add_sample(1, 65536, 32'h6400_0000);
        add_sample(COLUMNS - 1, 256, 32'hFF55_AA55);
        add_sample(COLUMNS, 256, 32'hFF00_FF00);
        add_sample(2047, 0, 32'hFFFF_FFFF);
        add_sample(2, 0, 32'hFF00_0000);
        add_sample(3, 1, 32'h00FF_FFFF);
        add_sample(3, 131071, 32'h8000_0000);
        add_sample(1023, 300, 32'hE0AA_AAAA);
        add_sample(1024, 300, 32'hE055_5555);
        add_clear();
        add_sample(0, 256, 32'hE6FF_FFFF);
        add_sample(1, 512, 32'hD200_0000);
        add_sample(1, 4096, 32'hC800_0001);
        add_clear();
        add_clear();
        add_sample(1, 4096, 32'hC800_0001);
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: apply_setting(12'h800, 12'h3FF, 12'h000, 12'h3FF);
                1: apply_setting(12'h7FF, 12'h000, 12'h3FF, 12'h001);
                2: apply_setting(12'h000, 12'hC01, 12'h200, 12'h000);
                3: apply_setting(12'hFFF, 12'h3FF, 12'h3FF, 12'h3FF);
                7: apply_setting(12'(vtcs_pkg::CAMERA_HEIGHT_RST), 12'(vtcs_pkg::HEIGHT_SCALE_RST),
                                 12'(vtcs_pkg::HORIZON_ROW_RST), 12'(vtcs_pkg::SCREEN_ROWS_RST));
                default: apply_setting(vtcs_pkg::CFG_W'($urandom_range(0, 4095)),
                                       vtcs_pkg::CFG_W'($urandom_range(0, 4095)),
                                       vtcs_pkg::CFG_W'($urandom_range(0, 4095)),
                                       vtcs_pkg::CFG_W'($urandom_range(1, 1023)));
            endcase
            @(negedge i_clk);
            // one phase runs with no idling on either side
            calm = (ph == 4);
            repeat (PHASE_ITEMS) add_random();
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (span_q.size() != 0)
            report_mismatch($sformatf("%0d spans never arrived", span_q.size()));
        $display("run covered %0d samples (%0d visible, %0d off-screen columns) and %0d clears",
                 n_samples, n_visible, n_offscreen, n_clears);
        $display("across %0d register settings, both sides idling at random", n_settings);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout: %0d requests pending, %0d spans outstanding",
                 request_q.size(), span_q.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
